FILE: design/lpd_pkg.sv
// ----------------------------------------------------------------------------
// lpd_pkg: shared constants and types of the LZSS pixel decoder
// Window geometry, field widths, command kinds and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package lpd_pkg;

	localparam int WINDOW_DEPTH  = 4096;
	localparam int WIN_AW        = $clog2(WINDOW_DEPTH);
	localparam int MAX_DIMENSION = 1023;
	localparam int DIM_W         = 10;
	localparam int PIX_CNT_W     = 20;
	localparam int DIST_W        = 12;
	localparam int LEN_W         = 6;
	localparam int MIN_MATCH     = 3;
	localparam int SRC_W         = ((WIN_AW > DIST_W) ? WIN_AW : DIST_W) + 1;

	typedef logic [2:0] kind_t;

	localparam kind_t K_STICKY    = 3'd0;
	localparam kind_t K_AFTER_END = 3'd1;
	localparam kind_t K_CONTROL   = 3'd2;
	localparam kind_t K_LITERAL   = 3'd3;
	localparam kind_t K_REF_LOW   = 3'd4;
	localparam kind_t K_BAD_DIST  = 3'd5;
	localparam kind_t K_OVERRUN   = 3'd6;
	localparam kind_t K_COPY      = 3'd7;

	typedef struct packed {
		logic accept;
		logic step;
		logic emit;
		logic copy_load;
		logic copy_read;
		logic copy_pixel;
	} dp_cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  out_free;
		logic  copy_last;
	} dp_status_t;

endpackage

`default_nettype wire

FILE: design/lpd_ram.sv
// ----------------------------------------------------------------------------
// lpd_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lpd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: design/lpd_ctrl.sv
// ----------------------------------------------------------------------------
// lpd_ctrl: sequencing state machine of the LZSS pixel decoder
// Accepts one byte, evaluates it, and runs the read/write cycles of a copy.
// ----------------------------------------------------------------------------
`default_nettype none

module lpd_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire lpd_pkg::dp_status_t st,
	output lpd_pkg::dp_cmd_t         cmd
);

	localparam logic [1:0] S_IDLE    = 2'd0;
	localparam logic [1:0] S_EXEC    = 2'd1;
	localparam logic [1:0] S_COPY_RD = 2'd2;
	localparam logic [1:0] S_COPY_WR = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		in_stall = (state_q != S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = S_EXEC;
				end
			end
			S_EXEC: begin
				if (st.kind inside {lpd_pkg::K_CONTROL, lpd_pkg::K_REF_LOW}) begin
					cmd.step = 1'b1;
					state_d  = S_IDLE;
				end else if (st.kind == lpd_pkg::K_COPY) begin
					cmd.copy_load = 1'b1;
					state_d       = S_COPY_RD;
				end else if (st.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_COPY_RD: begin
				cmd.copy_read = 1'b1;
				state_d       = S_COPY_WR;
			end
			S_COPY_WR: begin
				if (st.out_free) begin
					cmd.copy_pixel = 1'b1;
					state_d        = st.copy_last ? S_IDLE : S_COPY_RD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COPY_WR) |-> ($past(state_q) == S_COPY_RD || $past(state_q) == S_COPY_WR))
		else $error("copy write cycle entered without a window read");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> (state_q == S_EXEC))
		else $error("accepted byte not evaluated");

	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.copy_pixel && st.copy_last) |=> !in_stall)
		else $error("decoder not idle after final copied pixel");

endmodule

`default_nettype wire

FILE: design/lpd_dp.sv
// ----------------------------------------------------------------------------
// lpd_dp: datapath of the LZSS pixel decoder
// Stream parse state, history window, copy counters and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lpd_dp (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire lpd_pkg::dp_cmd_t                    cmd,
	output lpd_pkg::dp_status_t                      st,
	input  wire logic [7:0]                          data_byte,
	input  wire logic                                start_of_image,
	input  wire logic                                wide_mode,
	input  wire logic [lpd_pkg::PIX_CNT_W-1:0]       total_pixels,
	input  wire logic                                out_stall,
	output logic                                     out_valid,
	output logic [7:0]                               pixel,
	output logic                                     last_of_run,
	output logic                                     image_done,
	output logic [1:0]                               status
);

	localparam logic [1:0] PH_CONTROL  = 2'd0;
	localparam logic [1:0] PH_LITERAL  = 2'd1;
	localparam logic [1:0] PH_REF_LOW  = 2'd2;
	localparam logic [1:0] PH_REF_HIGH = 2'd3;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BAD_DIST  = 2'd1;
	localparam logic [1:0] ST_OVERRUN   = 2'd2;
	localparam logic [1:0] ST_AFTER_END = 2'd3;

	localparam int AW = lpd_pkg::WIN_AW;
	localparam int CW = lpd_pkg::PIX_CNT_W;
	localparam int DW = lpd_pkg::DIST_W;
	localparam int LW = lpd_pkg::LEN_W;
	localparam int SW = lpd_pkg::SRC_W;

	logic [7:0]    byte_q;
	logic [1:0]    phase_q;
	logic [7:0]    ctrl_bits_q;
	logic [2:0]    cmd_idx_q;
	logic [7:0]    low_q;
	logic [CW-1:0] pw_q;
	logic [AW-1:0] wp_q;
	logic [1:0]    sticky_q;
	logic [LW-1:0] len_q;
	logic [DW-1:0] dist_q;
	logic          out_valid_q;
	logic [7:0]    pixel_q;
	logic          last_q;
	logic          done_q;
	logic [1:0]    status_q;

	logic [15:0]   ref_word;
	logic [DW-1:0] dist_w;
	logic [LW-1:0] len_w;
	logic [CW-1:0] remain;
	logic          dist_bad;
	logic          overrun;
	lpd_pkg::kind_t kind;
	logic [CW-1:0] pw_inc;
	logic [AW-1:0] wp_inc;
	logic [2:0]    next_idx;
	logic [1:0]    next_phase;
	logic [SW-1:0] src_full;
	logic [AW-1:0] src_addr;
	logic          ram_we;
	logic [7:0]    ram_wdata;
	logic [7:0]    ram_rdata;
	logic          out_free;
	logic [1:0]    emit_status;

	assign ref_word = {byte_q, low_q};

	always_comb begin
		if (wide_mode) begin
			dist_w = {1'b0, ref_word[15:5]};
			len_w  = LW'(ref_word[4:0]) + LW'(lpd_pkg::MIN_MATCH);
		end else begin
			dist_w = ref_word[15:4];
			len_w  = LW'(ref_word[3:0]) + LW'(lpd_pkg::MIN_MATCH);
		end
	end

	assign remain   = total_pixels - pw_q;
	assign dist_bad = (dist_w == '0) || (CW'(dist_w) > pw_q)
		|| (32'(dist_w) > lpd_pkg::WINDOW_DEPTH);
	assign overrun  = (CW'(len_w) > remain);

	always_comb begin
		if (sticky_q != ST_OK) begin
			kind = lpd_pkg::K_STICKY;
		end else if (pw_q >= total_pixels) begin
			kind = lpd_pkg::K_AFTER_END;
		end else begin
			case (phase_q)
				PH_CONTROL: kind = lpd_pkg::K_CONTROL;
				PH_LITERAL: kind = lpd_pkg::K_LITERAL;
				PH_REF_LOW: kind = lpd_pkg::K_REF_LOW;
				default: begin
					if (dist_bad) begin
						kind = lpd_pkg::K_BAD_DIST;
					end else if (overrun) begin
						kind = lpd_pkg::K_OVERRUN;
					end else begin
						kind = lpd_pkg::K_COPY;
					end
				end
			endcase
		end
	end

	always_comb begin
		case (kind)
			lpd_pkg::K_STICKY:    emit_status = sticky_q;
			lpd_pkg::K_AFTER_END: emit_status = ST_AFTER_END;
			lpd_pkg::K_BAD_DIST:  emit_status = ST_BAD_DIST;
			lpd_pkg::K_OVERRUN:   emit_status = ST_OVERRUN;
			default:              emit_status = ST_OK;
		endcase
	end

	assign pw_inc     = pw_q + CW'(1);
	assign wp_inc     = (wp_q == AW'(lpd_pkg::WINDOW_DEPTH - 1)) ? '0 : wp_q + AW'(1);
	assign next_idx   = cmd_idx_q + 3'd1;
	assign next_phase = (next_idx == 3'd0) ? PH_CONTROL
		: (ctrl_bits_q[next_idx] ? PH_LITERAL : PH_REF_LOW);

	assign src_full = (SW'(wp_q) >= SW'(dist_q))
		? SW'(wp_q) - SW'(dist_q)
		: SW'(wp_q) + SW'(lpd_pkg::WINDOW_DEPTH) - SW'(dist_q);
	assign src_addr = src_full[AW-1:0];

	assign out_free  = !out_valid_q || !out_stall;
	assign ram_we    = (cmd.emit && (kind == lpd_pkg::K_LITERAL)) || cmd.copy_pixel;
	assign ram_wdata = cmd.copy_pixel ? ram_rdata : byte_q;

	assign st.kind      = kind;
	assign st.out_free  = out_free;
	assign st.copy_last = (len_q == LW'(1));

	lpd_ram #(
		.WIDTH(8),
		.DEPTH(lpd_pkg::WINDOW_DEPTH)
	) u_window (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wp_q),
		.wdata(ram_wdata),
		.re   (cmd.copy_read),
		.raddr(src_addr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_CONTROL;
			ctrl_bits_q <= '0;
			cmd_idx_q   <= '0;
			low_q       <= '0;
			pw_q        <= '0;
			wp_q        <= '0;
			sticky_q    <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.accept && start_of_image) begin
				phase_q   <= PH_CONTROL;
				cmd_idx_q <= '0;
				pw_q      <= '0;
				wp_q      <= '0;
				sticky_q  <= ST_OK;
			end
			if (cmd.step) begin
				if (kind == lpd_pkg::K_CONTROL) begin
					ctrl_bits_q <= byte_q;
					cmd_idx_q   <= '0;
					phase_q     <= byte_q[0] ? PH_LITERAL : PH_REF_LOW;
				end else begin
					low_q   <= byte_q;
					phase_q <= PH_REF_HIGH;
				end
			end
			if (cmd.emit) begin
				case (kind)
					lpd_pkg::K_AFTER_END: sticky_q <= ST_AFTER_END;
					lpd_pkg::K_BAD_DIST:  sticky_q <= ST_BAD_DIST;
					lpd_pkg::K_OVERRUN:   sticky_q <= ST_OVERRUN;
					lpd_pkg::K_LITERAL: begin
						pw_q      <= pw_inc;
						wp_q      <= wp_inc;
						phase_q   <= next_phase;
						cmd_idx_q <= next_idx;
					end
					default: begin
					end
				endcase
			end
			if (cmd.copy_pixel) begin
				pw_q <= pw_inc;
				wp_q <= wp_inc;
				if (st.copy_last) begin
					phase_q   <= next_phase;
					cmd_idx_q <= next_idx;
				end
			end
			if (cmd.emit || cmd.copy_pixel) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			byte_q <= data_byte;
		end
		if (cmd.copy_load) begin
			len_q  <= len_w;
			dist_q <= dist_w;
		end else if (cmd.copy_pixel) begin
			len_q <= len_q - LW'(1);
		end
		if (cmd.emit) begin
			pixel_q  <= (kind == lpd_pkg::K_LITERAL) ? byte_q : 8'd0;
			last_q   <= 1'b1;
			done_q   <= (kind == lpd_pkg::K_LITERAL) && (pw_inc == total_pixels);
			status_q <= emit_status;
		end else if (cmd.copy_pixel) begin
			pixel_q  <= ram_rdata;
			last_q   <= st.copy_last;
			done_q   <= (pw_inc == total_pixels);
			status_q <= ST_OK;
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel       = pixel_q;
	assign last_of_run = last_q;
	assign image_done  = done_q;
	assign status      = status_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit || cmd.copy_pixel) |-> out_free)
		else $error("output register overwritten while held");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.copy_pixel |-> (len_q != '0))
		else $error("copy pixel with empty run count");

	assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.copy_read && ram_we))
		else $error("window read and write in the same cycle");

	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit || cmd.copy_pixel) |=> out_valid_q)
		else $error("loaded transaction not presented");

endmodule

`default_nettype wire

FILE: design/lzss_pixel_decoder.sv
// ----------------------------------------------------------------------------
// lzss_pixel_decoder: LZSS decoder for an 8-bit image stream
// Decodes control, literal and back reference bytes into pixels through a
// history window; configuration registers replace the stream header.
//
//   channel | handshake              | payload
//   --------+------------------------+------------------------------------------
//   input   | in_valid / in_stall    | data_byte, start_of_image
//   output  | out_valid / out_stall  | pixel, last_of_run, image_done, status
//   config  | psel/penable/pwrite    | paddr, pwdata, prdata, pready
//
// Each byte is accepted in the idle state and then evaluated; a back reference
// copies its pixels through the window RAM, in which each pixel needs a
// registered read followed by the write of that pixel.
// Reset clears control state only; window contents are undefined until written.
// Output stall holds literal, error and copy steps; input is taken only when idle.
// ----------------------------------------------------------------------------
`default_nettype none

module lzss_pixel_decoder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        start_of_image,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic      [7:0]  pixel,
	output logic             last_of_run,
	output logic             image_done,
	output logic      [1:0]  status
);

	localparam logic [1:0] REG_MODE   = 2'd0;
	localparam logic [1:0] REG_WIDTH  = 2'd1;
	localparam logic [1:0] REG_HEIGHT = 2'd2;

	localparam int DW = lpd_pkg::DIM_W;
	localparam int CW = lpd_pkg::PIX_CNT_W;

	function automatic logic [DW-1:0] clamp_dim(input logic [DW-1:0] v);
		return (32'(v) > lpd_pkg::MAX_DIMENSION) ? DW'(lpd_pkg::MAX_DIMENSION) : v;
	endfunction

	logic          mode_q;
	logic [DW-1:0] width_q;
	logic [DW-1:0] height_q;
	logic [CW-1:0] total_q;
	logic          cfg_wr;

	lpd_pkg::dp_cmd_t    cmd;
	lpd_pkg::dp_status_t st;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 1'b0;
			width_q  <= DW'(1);
			height_q <= DW'(1);
			total_q  <= CW'(1);
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_MODE: begin
					mode_q <= pwdata[0];
				end
				REG_WIDTH: begin
					width_q <= pwdata[DW-1:0];
					total_q <= CW'(clamp_dim(pwdata[DW-1:0])) * CW'(clamp_dim(height_q));
				end
				REG_HEIGHT: begin
					height_q <= pwdata[DW-1:0];
					total_q  <= CW'(clamp_dim(width_q)) * CW'(clamp_dim(pwdata[DW-1:0]));
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_MODE:   prdata = {31'd0, mode_q};
			REG_WIDTH:  prdata = {{(32 - DW){1'b0}}, width_q};
			REG_HEIGHT: prdata = {{(32 - DW){1'b0}}, height_q};
			default:    prdata = '0;
		endcase
	end

	lpd_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.st      (st),
		.cmd     (cmd)
	);

	lpd_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.data_byte     (data_byte),
		.start_of_image(start_of_image),
		.wide_mode     (mode_q),
		.total_pixels  (total_q),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.pixel         (pixel),
		.last_of_run   (last_of_run),
		.image_done    (image_done),
		.status        (status)
	);

endmodule

`default_nettype wire
